@@ hdl/assert_macros.svh @@
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/dpgc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dpgc_pkg;

	localparam int COORD_BITS = 10;
	localparam int CMP_W      = 16;

	localparam logic [9:0]  MS_PER_SEC         = 10'd1000;
	localparam logic [21:0] DEF_TIMEOUT_MS     = 22'd10000;
	localparam logic [15:0] DEF_PALM_HOLD_MS   = 16'd2500;
	localparam logic [7:0]  DEF_PALM_SLOP_PX   = 8'd15;
	localparam logic [11:0] DEF_DOUBLE_TAP_MS  = 12'd400;

	typedef enum logic [3:0] {
		CMD_TICK      = 4'd0,
		CMD_PRESS     = 4'd1,
		CMD_HOLD      = 4'd2,
		CMD_RELEASE   = 4'd3,
		CMD_SLEEP_REQ = 4'd4,
		CMD_WAKE      = 4'd5,
		CMD_DEEP      = 4'd6,
		CMD_OFF       = 4'd7,
		CMD_TIMED_OFF = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ON    = 2'd0,
		ST_AOD   = 2'd1,
		ST_SLEEP = 2'd2,
		ST_DEEP  = 2'd3
	} pstate_t;

	typedef enum logic [1:0] {
		PCMD_ON    = 2'd0,
		PCMD_SLEEP = 2'd1,
		PCMD_AOD   = 2'd2,
		PCMD_OFF   = 2'd3
	} pcmd_t;

	typedef enum logic [1:0] {
		EV_ON    = 2'd0,
		EV_SLEEP = 2'd1,
		EV_AOD   = 2'd2
	} ev_t;

	typedef enum logic [2:0] {
		REG_AOD_ENABLE    = 3'd0,
		REG_SLEEP_TIMEOUT = 3'd1,
		REG_PALM_HOLD     = 3'd2,
		REG_PALM_SLOP     = 3'd3,
		REG_DOUBLE_TAP    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        aod_enable;
		logic [21:0] timeout_ms;
		logic [15:0] palm_hold_ms;
		logic [7:0]  palm_slop_px;
		logic [11:0] double_tap_ms;
	} cfg_t;

	typedef struct packed {
		pstate_t     new_state;
		pcmd_t       power_cmd;
		ev_t         event_code;
		logic        off_timed;
		logic [16:0] off_wake_sec;
	} res_t;

	function automatic res_t enter_res(pstate_t st, pcmd_t pc);
		res_t r;
		r.new_state    = st;
		r.power_cmd    = pc;
		r.off_timed    = 1'b0;
		r.off_wake_sec = 17'd0;
		case (st)
			ST_ON:   r.event_code = EV_ON;
			ST_AOD:  r.event_code = EV_AOD;
			default: r.event_code = EV_SLEEP;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/dpgc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dpgc_evt_if import dpgc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [3:0]            cmd;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;
	logic [16:0]           seconds;

	modport source (output valid, output cmd, output touch_x, output touch_y,
		output seconds, input ready);
	modport sink (input valid, input cmd, input touch_x, input touch_y,
		input seconds, output ready);
endinterface

interface dpgc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  new_state;
	logic [1:0]  power_cmd;
	logic [1:0]  event_code;
	logic        off_timed;
	logic [16:0] off_wake_sec;

	modport source (output valid, output new_state, output power_cmd, output event_code,
		output off_timed, output off_wake_sec, input ready);
	modport sink (input valid, input new_state, input power_cmd, input event_code,
		input off_timed, input off_wake_sec, output ready);
endinterface

`default_nettype wire

@@ hdl/dpgc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpgc_cfg import dpgc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data,
	output cfg_t             cfg
);

	cfg_t        cfg_q;
	logic [21:0] timeout_ms;

	// timeout kept in milliseconds, scaled once at write time
	assign timeout_ms = 22'(wr_data[11:0]) * 22'(MS_PER_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aod_enable    <= 1'b0;
			cfg_q.timeout_ms    <= DEF_TIMEOUT_MS;
			cfg_q.palm_hold_ms  <= DEF_PALM_HOLD_MS;
			cfg_q.palm_slop_px  <= DEF_PALM_SLOP_PX;
			cfg_q.double_tap_ms <= DEF_DOUBLE_TAP_MS;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_AOD_ENABLE:    cfg_q.aod_enable    <= wr_data[0];
				REG_SLEEP_TIMEOUT: cfg_q.timeout_ms    <= timeout_ms;
				REG_PALM_HOLD:     cfg_q.palm_hold_ms  <= wr_data;
				REG_PALM_SLOP:     cfg_q.palm_slop_px  <= wr_data[7:0];
				REG_DOUBLE_TAP:    cfg_q.double_tap_ms <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/dpgc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpgc_engine import dpgc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dpgc_evt_if.sink   evt,
	input  wire cfg_t  cfg,
	input  wire logic  take,
	output logic       out_valid,
	output res_t       out_data
);

	// input stage
	logic                  valid_s1;
	logic [3:0]            cmd_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [16:0]           sec_s1;
	logic                  fire;

	// controller state
	pstate_t               power_q, power_d;
	logic [31:0]           now_q, now_d;
	logic [21:0]           idle_q, idle_d;
	logic                  paused_q, paused_d;
	logic [31:0]           press_t_q, press_t_d;
	logic [COORD_BITS-1:0] press_x_q, press_x_d;
	logic [COORD_BITS-1:0] press_y_q, press_y_d;
	logic                  pressing_q, pressing_d;
	logic                  armed_q, armed_d;
	logic [31:0]           first_tap_q, first_tap_d;
	logic [26:0]           dw_left_q, dw_left_d;
	logic                  dw_active_q, dw_active_d;

	logic                  go;
	pstate_t               go_st;
	pcmd_t                 go_pc;
	pstate_t               sleep_st;
	pcmd_t                 sleep_pc;
	logic [21:0]           idle_inc;
	logic [26:0]           dw_dec;
	logic [26:0]           sec_ms;
	logic [31:0]           tap_gap;
	logic [31:0]           hold_len;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic                  still;
	res_t                  res;

	assign fire      = valid_s1 && take;
	assign evt.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			cmd_s1 <= evt.cmd;
			x_s1   <= evt.touch_x;
			y_s1   <= evt.touch_y;
			sec_s1 <= evt.seconds;
		end
	end

	assign sleep_st = cfg.aod_enable ? ST_AOD : ST_SLEEP;
	assign sleep_pc = cfg.aod_enable ? PCMD_AOD : PCMD_SLEEP;
	assign idle_inc = idle_q + 22'd1;
	assign dw_dec   = (dw_left_q != 27'd0) ? dw_left_q - 27'd1 : 27'd0;
	assign sec_ms   = 27'(sec_s1) * 27'(MS_PER_SEC);
	assign tap_gap  = now_q - first_tap_q;
	assign hold_len = now_q - press_t_q;
	assign dx       = (x_s1 > press_x_q) ? x_s1 - press_x_q : press_x_q - x_s1;
	assign dy       = (y_s1 > press_y_q) ? y_s1 - press_y_q : press_y_q - y_s1;
	assign still    = (CMP_W'(dx) <= CMP_W'(cfg.palm_slop_px)) &&
		(CMP_W'(dy) <= CMP_W'(cfg.palm_slop_px));

	always_comb begin
		power_d     = power_q;
		now_d       = now_q;
		idle_d      = idle_q;
		paused_d    = paused_q;
		press_t_d   = press_t_q;
		press_x_d   = press_x_q;
		press_y_d   = press_y_q;
		pressing_d  = pressing_q;
		armed_d     = armed_q;
		first_tap_d = first_tap_q;
		dw_left_d   = dw_left_q;
		dw_active_d = dw_active_q;
		go          = 1'b0;
		go_st       = ST_ON;
		go_pc       = PCMD_ON;

		case (cmd_t'(cmd_s1))
			CMD_TICK: begin
				now_d = now_q + 32'd1;
				if (dw_active_q) begin
					dw_left_d = dw_dec;
					if (dw_dec == 27'd0) begin
						dw_active_d = 1'b0;
						go          = 1'b1;
					end
				end
				if (!go && !paused_q) begin
					if (idle_inc >= cfg.timeout_ms) begin
						go    = 1'b1;
						go_st = sleep_st;
						go_pc = sleep_pc;
					end else begin
						idle_d = idle_inc;
					end
				end
			end
			CMD_PRESS: begin
				press_x_d  = x_s1;
				press_y_d  = y_s1;
				press_t_d  = now_q;
				pressing_d = 1'b1;
				if (power_q == ST_DEEP) begin
					go = 1'b1;
				end else if (power_q != ST_ON) begin
					if (armed_q && (tap_gap < 32'(cfg.double_tap_ms))) begin
						armed_d = 1'b0;
						go      = 1'b1;
					end else begin
						first_tap_d = now_q;
						armed_d     = 1'b1;
					end
				end else begin
					paused_d = 1'b1;
					idle_d   = 22'd0;
				end
			end
			CMD_HOLD: begin
				if ((power_q == ST_ON) && pressing_q &&
					(hold_len >= 32'(cfg.palm_hold_ms)) && still) begin
					pressing_d = 1'b0;
					go         = 1'b1;
					go_st      = sleep_st;
					go_pc      = sleep_pc;
				end
			end
			CMD_RELEASE: begin
				pressing_d = 1'b0;
				if (power_q == ST_ON) begin
					paused_d = 1'b0;
					idle_d   = 22'd0;
				end
			end
			CMD_SLEEP_REQ: begin
				go    = 1'b1;
				go_st = sleep_st;
				go_pc = sleep_pc;
			end
			CMD_WAKE: begin
				go = 1'b1;
			end
			CMD_DEEP: begin
				go          = 1'b1;
				go_st       = ST_DEEP;
				go_pc       = PCMD_SLEEP;
				dw_active_d = (sec_s1 != 17'd0);
				dw_left_d   = (sec_s1 != 17'd0) ? sec_ms : 27'd0;
			end
			CMD_OFF, CMD_TIMED_OFF: begin
				go          = 1'b1;
				go_st       = ST_DEEP;
				go_pc       = PCMD_OFF;
				dw_active_d = 1'b0;
				dw_left_d   = 27'd0;
			end
			default: ;
		endcase

		// state entry clears the idle timer, running only when on
		if (go) begin
			power_d  = go_st;
			idle_d   = 22'd0;
			paused_d = (go_st != ST_ON);
		end

		res = enter_res(go_st, go_pc);
		if (cmd_t'(cmd_s1) == CMD_TIMED_OFF) begin
			res.off_timed    = 1'b1;
			res.off_wake_sec = sec_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q     <= ST_ON;
			now_q       <= 32'd0;
			idle_q      <= 22'd0;
			paused_q    <= 1'b0;
			press_t_q   <= 32'd0;
			press_x_q   <= '0;
			press_y_q   <= '0;
			pressing_q  <= 1'b0;
			armed_q     <= 1'b0;
			first_tap_q <= 32'd0;
			dw_left_q   <= 27'd0;
			dw_active_q <= 1'b0;
		end else if (fire) begin
			power_q     <= power_d;
			now_q       <= now_d;
			idle_q      <= idle_d;
			paused_q    <= paused_d;
			press_t_q   <= press_t_d;
			press_x_q   <= press_x_d;
			press_y_q   <= press_y_d;
			pressing_q  <= pressing_d;
			armed_q     <= armed_d;
			first_tap_q <= first_tap_d;
			dw_left_q   <= dw_left_d;
			dw_active_q <= dw_active_d;
		end
	end

	assign out_valid = fire && go;
	assign out_data  = res;

endmodule

`default_nettype wire

@@ hdl/dpgc_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpgc_out_reg import dpgc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire res_t  in_data,
	output logic       take,
	dpgc_res_if.source res
);

	logic valid_q;
	res_t data_q;

	assign take = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			data_q <= in_data;
		end
	end

	assign res.valid        = valid_q;
	assign res.new_state    = data_q.new_state;
	assign res.power_cmd    = data_q.power_cmd;
	assign res.event_code   = data_q.event_code;
	assign res.off_timed    = data_q.off_timed;
	assign res.off_wake_sec = data_q.off_wake_sec;

endmodule

`default_nettype wire

@@ hdl/display_power_gesture_controller_core.sv @@
// channel   dir   beat carries
// evt       in    cmd, touch_x, touch_y, seconds
// res       out   new_state, power_cmd, event_code, off_timed, off_wake_sec
// wr_*      in    register write: wr_en, wr_index, wr_data
//
// one event beat per cycle while res is not stalled
// the input register feeds a combinational state update into the result register
// events that enter no power state give no result beat
// a stalled res holds its beat; evt keeps taking one more beat into the input register
// reset restores default registers and the display-on state, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module display_power_gesture_controller_core import dpgc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dpgc_evt_if.sink         evt,
	dpgc_res_if.source       res,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data
);

	cfg_t cfg;
	logic take;
	logic eng_valid;
	res_t eng_data;

	dpgc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	dpgc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.cfg       (cfg),
		.take      (take),
		.out_valid (eng_valid),
		.out_data  (eng_data)
	);

	dpgc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (eng_valid),
		.in_data  (eng_data),
		.take     (take),
		.res      (res)
	);

endmodule

`default_nettype wire

@@ hdl/dpgc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpgc_checker import dpgc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  new_state,
	input wire logic [1:0]  power_cmd,
	input wire logic [1:0]  event_code,
	input wire logic        off_timed,
	input wire logic [16:0] off_wake_sec
);

	logic        res_stall;
	logic        codes_ok;
	logic [23:0] res_beat;

	assign res_stall = res_valid && !res_ready;
	assign res_beat  = {new_state, power_cmd, event_code, off_timed, off_wake_sec};
	assign codes_ok  = ((new_state == ST_ON) == (power_cmd == PCMD_ON)) &&
		((new_state == ST_AOD) == (event_code == EV_AOD));

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid)
	`ASSERT_NEXT(a_res_stable, clk, arst_n, res_stall, $stable(res_beat))
	`ASSERT_IMPLY(a_code_match, clk, arst_n, res_valid, codes_ok)
	`ASSERT_IMPLY(a_timed_off, clk, arst_n, res_valid && off_timed, (new_state == ST_DEEP) && (power_cmd == PCMD_OFF))

endmodule

bind display_power_gesture_controller_core dpgc_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.new_state    (res.new_state),
	.power_cmd    (res.power_cmd),
	.event_code   (res.event_code),
	.off_timed    (res.off_timed),
	.off_wake_sec (res.off_wake_sec)
);

`default_nettype wire

@@ tb/sv/display_power_gesture_controller_core_test.sv @@
`timescale 1ns / 1ps

module display_power_gesture_controller_core_test;
	import dpgc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [3:0]            cmd;
		logic [COORD_BITS-1:0] touch_x;
		logic [COORD_BITS-1:0] touch_y;
		logic [16:0]           seconds;
	} evt_beat_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	dpgc_evt_if evt_ch();
	dpgc_res_if res_ch();

	display_power_gesture_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// register copies
	logic        cfg_aod       = 1'b0;
	logic [11:0] cfg_timeout_s = 12'd10;
	logic [15:0] cfg_palm_ms   = DEF_PALM_HOLD_MS;
	logic [7:0]  cfg_slop      = DEF_PALM_SLOP_PX;
	logic [11:0] cfg_tap_ms    = DEF_DOUBLE_TAP_MS;

	// display state copy
	pstate_t     disp_state  = ST_ON;
	logic [31:0] ms_now      = 32'd0;
	logic [21:0] idle_ms     = 22'd0;
	logic        idle_hold   = 1'b0;
	logic [31:0] touch_t     = 32'd0;
	logic [9:0]  touch_px    = 10'd0;
	logic [9:0]  touch_py    = 10'd0;
	logic        touching    = 1'b0;
	logic        tap_pending = 1'b0;
	logic [31:0] tap_t       = 32'd0;
	logic [26:0] wake_left   = 27'd0;
	logic        wake_armed  = 1'b0;

	evt_beat_t pend_beats[$];
	res_t      due_results[$];
	evt_beat_t cur_beat;
	res_t      want_res;
	int        send_wait;
	int        take_wait;
	int        quiet_cycles;
	int        mismatches;
	int        queued;
	logic      no_idle;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic int clamp_coord(input int v);
		return v < 0 ? 0 : (v > 1023 ? 1023 : v);
	endfunction

	task automatic post_entry(input pstate_t st, input pcmd_t pc, input logic timed,
			input logic [16:0] wake_s);
		res_t r;
		disp_state = st;
		idle_ms = 22'd0;
		idle_hold = (st != ST_ON);
		r.new_state = st;
		r.power_cmd = pc;
		r.event_code = (st == ST_ON) ? EV_ON : ((st == ST_AOD) ? EV_AOD : EV_SLEEP);
		r.off_timed = timed;
		r.off_wake_sec = wake_s;
		due_results.push_back(r);
	endtask

	task automatic request_rest();
		if (cfg_aod)
			post_entry(ST_AOD, PCMD_AOD, 1'b0, 17'd0);
		else
			post_entry(ST_SLEEP, PCMD_SLEEP, 1'b0, 17'd0);
	endtask

	task automatic advance_display(input evt_beat_t b);
		logic        fired;
		logic [31:0] limit_ms;
		logic [9:0]  dx;
		logic [9:0]  dy;
		case (b.cmd)
			CMD_TICK: begin
				ms_now = ms_now + 32'd1;
				fired = 1'b0;
				if (wake_armed) begin
					if (wake_left != 27'd0)
						wake_left = wake_left - 27'd1;
					if (wake_left == 27'd0) begin
						wake_armed = 1'b0;
						post_entry(ST_ON, PCMD_ON, 1'b0, 17'd0);
						fired = 1'b1;
					end
				end
				if (!fired && !idle_hold) begin
					idle_ms = idle_ms + 22'd1;
					limit_ms = cfg_timeout_s * 32'd1000;
					if ({10'd0, idle_ms} >= limit_ms) begin
						request_rest();
						idle_hold = 1'b1;
						idle_ms = 22'd0;
					end
				end
			end
			CMD_PRESS: begin
				touch_px = b.touch_x;
				touch_py = b.touch_y;
				touch_t = ms_now;
				touching = 1'b1;
				if (disp_state == ST_DEEP) begin
					post_entry(ST_ON, PCMD_ON, 1'b0, 17'd0);
				end else if (disp_state != ST_ON) begin
					if (tap_pending && (ms_now - tap_t) < {20'd0, cfg_tap_ms}) begin
						tap_pending = 1'b0;
						post_entry(ST_ON, PCMD_ON, 1'b0, 17'd0);
					end else begin
						tap_t = ms_now;
						tap_pending = 1'b1;
					end
				end else begin
					idle_hold = 1'b1;
					idle_ms = 22'd0;
				end
			end
			CMD_HOLD: begin
				dx = (b.touch_x > touch_px) ? b.touch_x - touch_px : touch_px - b.touch_x;
				dy = (b.touch_y > touch_py) ? b.touch_y - touch_py : touch_py - b.touch_y;
				if (disp_state == ST_ON && touching
						&& (ms_now - touch_t) >= {16'd0, cfg_palm_ms}
						&& dx <= cfg_slop && dy <= cfg_slop) begin
					touching = 1'b0;
					request_rest();
				end
			end
			CMD_RELEASE: begin
				touching = 1'b0;
				if (disp_state == ST_ON) begin
					idle_hold = 1'b0;
					idle_ms = 22'd0;
				end
			end
			CMD_SLEEP_REQ: request_rest();
			CMD_WAKE: post_entry(ST_ON, PCMD_ON, 1'b0, 17'd0);
			CMD_DEEP: begin
				wake_armed = 1'b0;
				wake_left = 27'd0;
				post_entry(ST_DEEP, PCMD_SLEEP, 1'b0, 17'd0);
				if (b.seconds != 17'd0) begin
					wake_left = b.seconds * 27'd1000;
					wake_armed = 1'b1;
				end
			end
			CMD_OFF, CMD_TIMED_OFF: begin
				wake_armed = 1'b0;
				wake_left = 27'd0;
				post_entry(ST_DEEP, PCMD_OFF, b.cmd == CMD_TIMED_OFF,
					(b.cmd == CMD_TIMED_OFF) ? b.seconds : 17'd0);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (evt_ch.valid && evt_ch.ready)
				advance_display(cur_beat);
			if (!evt_ch.valid || evt_ch.ready) begin
				if (send_wait > 0) begin
					send_wait = send_wait - 1;
					evt_ch.valid <= 1'b0;
				end else if (pend_beats.size() != 0) begin
					cur_beat = pend_beats.pop_front();
					evt_ch.valid <= 1'b1;
					evt_ch.cmd <= cur_beat.cmd;
					evt_ch.touch_x <= cur_beat.touch_x;
					evt_ch.touch_y <= cur_beat.touch_y;
					evt_ch.seconds <= cur_beat.seconds;
					send_wait = draw_wait();
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			take_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result beat with no expectation: state %0d cmd %0d",
						res_ch.new_state, res_ch.power_cmd);
					mismatches++;
				end else begin
					want_res = due_results.pop_front();
					check_field("new_state", int'(want_res.new_state),
						int'(res_ch.new_state));
					check_field("power_cmd", int'(want_res.power_cmd),
						int'(res_ch.power_cmd));
					check_field("event_code", int'(want_res.event_code),
						int'(res_ch.event_code));
					check_field("off_timed", int'(want_res.off_timed),
						int'(res_ch.off_timed));
					check_field("off_wake_sec", int'(want_res.off_wake_sec),
						int'(res_ch.off_wake_sec));
				end
				take_wait = draw_wait();
			end
			if (take_wait > 0) begin
				take_wait = take_wait - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || wr_en || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic add_item(input logic [3:0] c, input int x, input int y, input int sec);
		evt_beat_t b;
		b.cmd = c;
		b.touch_x = COORD_BITS'(x);
		b.touch_y = COORD_BITS'(y);
		b.seconds = 17'(sec);
		pend_beats.push_back(b);
		if (c <= CMD_TIMED_OFF)
			queued++;
	endtask

	task automatic add_ticks(input int n);
		for (int i = 0; i < n; i++)
			add_item(CMD_TICK, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 86400));
	endtask

	task automatic drain();
		@(negedge clk);
		while (pend_beats.size() != 0 || evt_ch.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_AOD_ENABLE:    cfg_aod = val[0];
			REG_SLEEP_TIMEOUT: cfg_timeout_s = val[11:0];
			REG_PALM_HOLD:     cfg_palm_ms = val;
			REG_PALM_SLOP:     cfg_slop = val[7:0];
			REG_DOUBLE_TAP:    cfg_tap_ms = val[11:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int aod, input int tmo, input int palm, input int slop,
			input int tap);
		drain();
		set_reg(REG_AOD_ENABLE, 16'(aod));
		set_reg(REG_SLEEP_TIMEOUT, 16'(tmo));
		set_reg(REG_PALM_HOLD, 16'(palm));
		set_reg(REG_PALM_SLOP, 16'(slop));
		set_reg(REG_DOUBLE_TAP, 16'(tap));
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_scenario();
		int x;
		int y;
		int k;
		int span;
		x = $urandom_range(0, 1023);
		y = $urandom_range(0, 1023);
		case ($urandom_range(0, 9))
			0, 1: add_item(4'($urandom_range(0, 15)), x, y,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 86400));
			2: add_ticks($urandom_range(1, 20));
			3, 4: begin
				// press, wait, then a hold near the press point
				if ($urandom_range(0, 1))
					add_item(CMD_WAKE, x, y, 0);
				add_item(CMD_PRESS, x, y, 0);
				k = (cfg_palm_ms <= 40) ? $urandom_range(0, cfg_palm_ms + 2)
					: $urandom_range(0, 10);
				add_ticks(k);
				span = (cfg_slop > 60) ? 300 : cfg_slop + 2;
				add_item(CMD_HOLD, clamp_coord(x + $urandom_range(0, 2 * span) - span),
					clamp_coord(y + $urandom_range(0, 2 * span) - span), 0);
				if ($urandom_range(0, 1))
					add_item(CMD_RELEASE, x, y, 0);
			end
			5, 6: begin
				// second press around the double-tap window
				add_item(CMD_SLEEP_REQ, x, y, 0);
				add_item(CMD_PRESS, x, y, 0);
				k = (cfg_tap_ms <= 48) ? $urandom_range(0, cfg_tap_ms + 2)
					: $urandom_range(0, 50);
				add_ticks(k);
				add_item(CMD_PRESS, y, x, 0);
				add_item(CMD_RELEASE, x, y, 0);
			end
			7: begin
				add_item($urandom_range(0, 1) ? CMD_OFF : CMD_TIMED_OFF, x, y,
					$urandom_range(0, 86400));
				add_item(CMD_PRESS, x, y, 0);
				add_item(CMD_RELEASE, x, y, 0);
			end
			8: begin
				add_item(CMD_RELEASE, x, y, 0);
				add_ticks($urandom_range(1, 5));
			end
			default: add_item(CMD_DEEP, x, y, $urandom_range(0, 3));
		endcase
	endtask

	initial begin
		int aod;
		int tmo;
		int palm;
		int slop;
		int tap;
		int goal;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		evt_ch.valid = 1'b0;
		evt_ch.cmd = '0;
		evt_ch.touch_x = '0;
		evt_ch.touch_y = '0;
		evt_ch.seconds = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		queued = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_PRESS, 0, 0, 0);
		add_item(CMD_HOLD, 1023, 1023, 0);
		add_item(CMD_RELEASE, 0, 0, 0);
		add_item(CMD_PRESS, 1023, 1023, 131071);
		add_item(CMD_RELEASE, 1023, 1023, 0);
		add_item(CMD_SLEEP_REQ, 0, 0, 0);
		add_item(CMD_PRESS, 5, 5, 0);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_PRESS, 6, 6, 0);
		add_item(CMD_RELEASE, 6, 6, 0);
		add_item(CMD_DEEP, 0, 0, 0);
		add_item(CMD_PRESS, 0, 0, 0);
		add_item(CMD_RELEASE, 0, 0, 0);
		add_item(CMD_OFF, 0, 0, 0);
		add_item(CMD_WAKE, 0, 0, 0);
		add_item(CMD_TIMED_OFF, 0, 0, 86400);
		add_item(CMD_WAKE, 0, 0, 0);
		add_item(4'd9, 1023, 0, 86400);
		add_item(4'd15, 0, 1023, 1);
		add_item(CMD_DEEP, 0, 0, 86400);
		add_item(CMD_WAKE, 0, 0, 0);
		configure(1, 0, 1, 0, 4095);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_WAKE, 0, 0, 0);
		add_item(CMD_PRESS, 100, 200, 0);
		add_item(CMD_TICK, 0, 0, 0);
		add_item(CMD_HOLD, 100, 200, 0);

		// countdown and idle timer land on the same tick, then the idle timer fires
		configure(0, 1, 2500, 15, 400);
		no_idle = 1'b1;
		add_item(CMD_DEEP, 0, 0, 1);
		add_item(CMD_WAKE, 0, 0, 0);
		add_ticks(2001);
		drain();
		no_idle = 1'b0;

		queued = 0;
		for (int ph = 0; ph < 7; ph++) begin
			aod = $urandom_range(0, 1);
			case ($urandom_range(0, 4))
				0: tmo = 0;
				1: tmo = 1;
				2: tmo = 3600;
				3: tmo = 4095;
				default: tmo = $urandom_range(0, 4095);
			endcase
			case ($urandom_range(0, 4))
				0: palm = 0;
				1: palm = 65535;
				2: palm = $urandom_range(0, 65535);
				default: palm = $urandom_range(1, 30);
			endcase
			case ($urandom_range(0, 3))
				0: slop = 0;
				1: slop = 255;
				default: slop = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 4))
				0: tap = 0;
				1: tap = 4095;
				2: tap = $urandom_range(0, 4095);
				default: tap = $urandom_range(1, 40);
			endcase
			if (ph == 0) begin
				tmo = 0;
				palm = 1;
				slop = 0;
				tap = 1;
			end else if (ph == 1) begin
				tmo = 4095;
				palm = 65535;
				slop = 255;
				tap = 4095;
			end
			configure(aod, tmo, palm, slop, tap);
			no_idle = (ph == 3);
			goal = queued + 86;
			while (queued < goal)
				add_scenario();
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
